FILE: rtl/cdrg_pkg.sv
// ----------------------------------------------------------------------------
// cdrg_pkg
// shared types and constants of the contact debounce and ramp gate
// ----------------------------------------------------------------------------
package cdrg_pkg;

    // widths
    localparam int REG_BITS   = 32;  // configuration registers
    localparam int TICK_BITS  = 32;  // timestamp field of the input word
    localparam int TIME_BITS  = 32;  // width of the time base (16..64)
    localparam int CALC_BITS  = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_BITS  = FRAC_BITS + 1;
    localparam int DIV_STEPS  = FRAC_BITS;
    localparam int COUNT_BITS = $clog2(DIV_STEPS);
    localparam int NUM_FEET   = 2;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE  = GAIN_BITS'(1) << FRAC_BITS;
    localparam logic [GAIN_BITS-1:0] GAIN_ZERO = '0;

    // foot lanes
    localparam int FOOT_LEFT  = 0;
    localparam int FOOT_RIGHT = 1;

    // configuration register map
    localparam int CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RAMP     = 1'b1;

    typedef struct packed {
        logic [TICK_BITS-1:0] now_ticks;
        logic                 contact_left;
        logic                 contact_right;
    } item_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0] gain_left;
        logic [GAIN_BITS-1:0] gain_right;
    } result_t;

    typedef enum logic [1:0] {
        LANE_IDLE,
        LANE_EVAL,
        LANE_DIV,
        LANE_DONE
    } lane_state_t;

    typedef struct packed {
        logic                 done;
        logic [GAIN_BITS-1:0] gain;
    } lane_status_t;

endpackage

FILE: rtl/cdrg_lane.sv
// ----------------------------------------------------------------------------
// cdrg_lane
// one foot: onset latch, debounce check and 16-step restoring ramp divider
// ----------------------------------------------------------------------------
module cdrg_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          contact,
    input  logic [cdrg_pkg::TIME_BITS-1:0] now_time,
    input  logic [cdrg_pkg::REG_BITS-1:0]  debounce,
    input  logic [cdrg_pkg::REG_BITS-1:0]  ramp,
    input  logic                          take,
    output cdrg_pkg::lane_status_t        status
);
    import cdrg_pkg::*;

    lane_state_t            state_reg, state_next;
    logic                   present_reg, present_next;
    logic [TIME_BITS-1:0]   stamp_reg, stamp_next;
    logic [TIME_BITS-1:0]   since_reg, since_next;
    logic                   contact_reg, contact_next;
    logic [CALC_BITS-1:0]   rem_reg, rem_next;
    logic [FRAC_BITS-1:0]   quot_reg, quot_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [GAIN_BITS-1:0]   gain_reg, gain_next;

    logic                   relatch;
    logic [CALC_BITS-1:0]   since_ext;
    logic [CALC_BITS-1:0]   deb_ext;
    logic [CALC_BITS-1:0]   ramp_ext;
    logic [CALC_BITS:0]     ramp_end;
    logic [CALC_BITS:0]     rem_shift;
    logic                   quot_bit;

    assign relatch   = !present_reg || (now_time < stamp_reg);
    assign since_ext = CALC_BITS'(since_reg);
    assign deb_ext   = CALC_BITS'(debounce);
    assign ramp_ext  = CALC_BITS'(ramp);
    // ramp is over once since reaches debounce + ramp
    assign ramp_end  = {1'b0, deb_ext} + {1'b0, ramp_ext};
    assign rem_shift = {rem_reg, 1'b0};
    assign quot_bit  = (rem_shift >= {1'b0, ramp_ext});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= LANE_IDLE;
            present_reg <= 1'b0;
            stamp_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            stamp_reg   <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        since_reg   <= since_next;
        contact_reg <= contact_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        count_reg   <= count_next;
        gain_reg    <= gain_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        present_next = present_reg;
        stamp_next   = stamp_reg;
        since_next   = since_reg;
        contact_next = contact_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        count_next   = count_reg;
        gain_next    = gain_reg;

        unique case (state_reg)
            LANE_IDLE:
            begin
                if (start)
                begin
                    contact_next = contact;
                    if (!contact)
                    begin
                        present_next = 1'b0;
                        stamp_next   = '0;
                        since_next   = '0;
                    end
                    else if (relatch)
                    begin
                        present_next = 1'b1;
                        stamp_next   = now_time;
                        since_next   = '0;
                    end
                    else
                    begin
                        since_next = now_time - stamp_reg;
                    end
                    state_next = LANE_EVAL;
                end
            end
            LANE_EVAL:
            begin
                if (!contact_reg || (since_ext < deb_ext))
                begin
                    gain_next  = GAIN_ZERO;
                    state_next = LANE_DONE;
                end
                else if ((ramp_ext == '0) || ({1'b0, since_ext} >= ramp_end))
                begin
                    gain_next  = GAIN_ONE;
                    state_next = LANE_DONE;
                end
                else
                begin
                    rem_next   = since_ext - deb_ext;
                    quot_next  = '0;
                    count_next = '0;
                    state_next = LANE_DIV;
                end
            end
            LANE_DIV:
            begin
                // one quotient bit per cycle, remainder stays below ramp
                if (quot_bit)
                    rem_next = CALC_BITS'(rem_shift - {1'b0, ramp_ext});
                else
                    rem_next = CALC_BITS'(rem_shift);
                quot_next  = {quot_reg[FRAC_BITS-2:0], quot_bit};
                count_next = count_reg + 1'b1;
                if (count_reg == COUNT_BITS'(DIV_STEPS - 1))
                begin
                    gain_next  = {1'b0, quot_next};
                    state_next = LANE_DONE;
                end
            end
            LANE_DONE:
            begin
                if (take)
                    state_next = LANE_IDLE;
            end
            default:
            begin
                state_next = LANE_IDLE;
            end
        endcase
    end

    assign status.done = (state_reg == LANE_DONE);
    assign status.gain = gain_reg;

endmodule

FILE: rtl/cdrg_merge.sv
// ----------------------------------------------------------------------------
// cdrg_merge
// joins the lane gains into one result word and holds it in the output register
// ----------------------------------------------------------------------------
module cdrg_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cdrg_pkg::lane_status_t lane_status [cdrg_pkg::NUM_FEET],
    input  logic                   result_ready,
    output logic                   take,
    output logic                   result_valid,
    output cdrg_pkg::result_t      result
);
    import cdrg_pkg::*;

    logic    valid_reg, valid_next;
    result_t word_reg, word_next;
    logic    all_done;

    assign all_done = lane_status[FOOT_LEFT].done & lane_status[FOOT_RIGHT].done;
    assign take     = all_done && (!valid_reg || result_ready);

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (take)
        begin
            valid_next           = 1'b1;
            word_next.gain_left  = lane_status[FOOT_LEFT].gain;
            word_next.gain_right = lane_status[FOOT_RIGHT].gain;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign result_valid = valid_reg;
    assign result       = word_reg;

endmodule

FILE: rtl/contact_debounce_ramp_gate.sv
// ----------------------------------------------------------------------------
// contact_debounce_ramp_gate
// per-foot contact debounce with a linear Q16 gain ramp, two feet in parallel
// ----------------------------------------------------------------------------
//
//  channel   handshake                  word
//  --------  -------------------------  ------------------------------------
//  item      item_valid / item_ready    now_ticks, contact_left/right
//  result    result_valid / result_ready gain_left, gain_right (Q16, 0..65536)
//  config    cfg_we (no wait)           cfg_addr, cfg_wdata
//
//  one item at a time; a gain of 0 or 1.0 goes from the EVAL state straight
//  to DONE, a gain on the ramp first passes through the 16-step restoring
//  divider in each lane; next item is taken the cycle after the result is
//  latched, and latching waits while the output holds an untaken result
//  the output register lets a new item in while a result waits to be taken
//  reset clears config, onsets, lanes and output valid; no clearing pass
//
module contact_debounce_ramp_gate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  cdrg_pkg::item_t                       item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output cdrg_pkg::result_t                     result,
    input  logic                                  cfg_we,
    input  logic [cdrg_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [cdrg_pkg::REG_BITS-1:0]         cfg_wdata
);
    import cdrg_pkg::*;

    // configuration registers
    logic [REG_BITS-1:0] debounce_reg;
    logic [REG_BITS-1:0] ramp_reg;

    // busy from accept until the merge stage latches the result
    logic busy_reg, busy_next;
    logic accept;
    logic take;

    logic [NUM_FEET-1:0]  contact_vec;
    logic [TIME_BITS-1:0] now_time;
    lane_status_t         lane_status [NUM_FEET];

    assign item_ready  = !busy_reg;
    assign accept      = item_valid && item_ready;
    // time base is the tick field sized to TIME_BITS
    assign now_time    = TIME_BITS'(item.now_ticks);
    assign contact_vec[FOOT_LEFT]  = item.contact_left;
    assign contact_vec[FOOT_RIGHT] = item.contact_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= '0;
            ramp_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                REG_RAMP:     ramp_reg     <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (take)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    // one lane per foot, each with its own onset state and divider
    for (genvar g = 0; g < NUM_FEET; g++)
    begin : g_lane
        cdrg_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (accept),
            .contact  (contact_vec[g]),
            .now_time (now_time),
            .debounce (debounce_reg),
            .ramp     (ramp_reg),
            .take     (take),
            .status   (lane_status[g])
        );
    end

    // merge both gains into the output register
    cdrg_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .lane_status  (lane_status),
        .result_ready (result_ready),
        .take         (take),
        .result_valid (result_valid),
        .result       (result)
    );

    // a finished lane holds its gain until the merge stage takes both; checked on the left lane
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        lane_status[FOOT_LEFT].done && !take |=> lane_status[FOOT_LEFT].done)
        else $error("lane left done before take");

    // an idle block has no finished lane waiting; checked on the left lane
    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !lane_status[FOOT_LEFT].done)
        else $error("lane done while block idle");

    // latching a result frees the input side
    a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> item_ready && result_valid)
        else $error("result latch did not free input");

    // gains never exceed 1.0
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.gain_left <= GAIN_ONE) && (result.gain_right <= GAIN_ONE))
        else $error("gain above one");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for contact_debounce_ramp_gate: directed corner words
// then random contact walks under several register settings, with gaps on
// the item side and stalls on the result side, each result word checked
// against an in-bench model of the onset latch, debounce and gain ramp
// ----------------------------------------------------------------------------
module testbench;

    import cdrg_pkg::*;

    // cycles to wait once nothing is pending: longest ramp latency plus margin
    localparam int SETTLE_CYCLES = 24;
    // hard stop, far above the slowest legal run
    localparam int CYCLE_LIMIT   = 300000;
    // mask that the block applies to the timestamp
    localparam logic [63:0] TIME_MASK =
        (TIME_BITS >= 64) ? '1 : ((64'd1 << TIME_BITS) - 64'd1);

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // item side
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item       = '0;

    // result side
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // register port
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = REG_DEBOUNCE;
    logic [REG_BITS-1:0]      cfg_wdata = '0;

    // words waiting to be offered, and gain words still owed by the block
    item_t   pending_items[$];
    result_t expected_gains[$];

    // model copy of the registers and of the per-foot onset latch
    logic [63:0] debounce_len = '0;
    logic [63:0] ramp_len     = '0;
    logic [63:0] onset_at[NUM_FEET]   = '{default: '0};
    logic        onset_held[NUM_FEET] = '{default: 1'b0};

    // bookkeeping
    logic item_taken = 1'b0;   // item word accepted at the last rising edge
    bit   idle_on    = 1'b0;   // random gaps and stalls enabled
    int   send_gap   = 0;
    int   hold_gap   = 0;
    int   errors     = 0;
    int   cycle_count = 0;

    // state of the random contact walk
    logic [31:0] walk_stamp;
    logic        walk_left;
    logic        walk_right;

    contact_debounce_ramp_gate i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // gain model
    // ------------------------------------------------------------------------

    // one foot: update its onset latch and return its q16 gain
    function automatic logic [GAIN_BITS-1:0] foot_gain(input int foot,
                                                       input logic [63:0] now,
                                                       input logic contact);
        logic [63:0] since;
        logic [63:0] past;
        logic [63:0] frac;
        // lifted foot forgets its onset
        if (!contact) begin
            onset_held[foot] = 1'b0;
            onset_at[foot]   = '0;
            return GAIN_ZERO;
        end
        // first contact, or time ran backwards past the onset: latch now
        if (!onset_held[foot] || now < onset_at[foot]) begin
            onset_at[foot]   = now;
            onset_held[foot] = 1'b1;
        end
        since = now - onset_at[foot];
        if (since < debounce_len)
            return GAIN_ZERO;
        // zero ramp is a plain step
        if (ramp_len == 0)
            return GAIN_ONE;
        past = since - debounce_len;
        if (past >= ramp_len)
            return GAIN_ONE;
        // past < ramp_len < 2^32, so the shift cannot overflow
        frac = (past << FRAC_BITS) / ramp_len;
        return frac[GAIN_BITS-1:0];
    endfunction

    function automatic result_t predict_gains(input item_t word);
        result_t     gains;
        logic [63:0] now;
        now              = 64'(word.now_ticks) & TIME_MASK;
        gains.gain_left  = foot_gain(FOOT_LEFT, now, word.contact_left);
        gains.gain_right = foot_gain(FOOT_RIGHT, now, word.contact_right);
        return gains;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: check result words first, then book the item word taken at
    // the same edge, so a stray result can never pair with a newer item
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        result_t want;
        item_taken <= item_valid && item_ready;
        if (result_valid && result_ready) begin
            if (expected_gains.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got left %0d right %0d",
                         $time, result.gain_left, result.gain_right);
                errors++;
            end else begin
                want = expected_gains.pop_front();
                if (result.gain_left !== want.gain_left) begin
                    $display("%0t: gain_left mismatch, expected %0d, got %0d",
                             $time, want.gain_left, result.gain_left);
                    errors++;
                end
                if (result.gain_right !== want.gain_right) begin
                    $display("%0t: gain_right mismatch, expected %0d, got %0d",
                             $time, want.gain_right, result.gain_right);
                    errors++;
                end
            end
        end
        if (item_valid && item_ready)
            expected_gains.push_back(predict_gains(item));
    end

    // ------------------------------------------------------------------------
    // driver: offer the next pending word at the falling edge; a word that
    // is up stays up, unchanged, until the edge that takes it
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : driver
        logic  next_valid;
        item_t next_item;
        next_valid = item_valid;
        next_item  = item;
        if (!idle_on)
            send_gap = 0;
        if (!item_valid || item_taken) begin
            next_valid = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
            end else if (pending_items.size() != 0) begin
                if (idle_on && $urandom_range(99, 0) < 20) begin
                    // burst of idle cycles, this one included
                    send_gap = $urandom_range(19, 1) - 1;
                end else begin
                    next_item  = pending_items.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        item_valid <= next_valid;
        item       <= next_item;
    end

    // result side stalls in bursts, regardless of result_valid
    always @(negedge clk) begin : sink
        if (!idle_on) begin
            hold_gap = 0;
            result_ready <= 1'b1;
        end else if (hold_gap != 0) begin
            hold_gap--;
            result_ready <= 1'b0;
        end else if ($urandom_range(99, 0) < 15) begin
            hold_gap = $urandom_range(19, 1) - 1;
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** contact_debounce_ramp_gate: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_item(input logic [31:0] now, input logic left,
                             input logic right);
        item_t word;
        word.now_ticks     = now;
        word.contact_left  = left;
        word.contact_right = right;
        pending_items.push_back(word);
    endtask

    // register write; the model copy follows, the block being idle here
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] index,
                             input logic [REG_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        if (index == REG_DEBOUNCE)
            debounce_len = 64'(value);
        else
            ramp_len = 64'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every word is offered, taken and answered, then let it settle
    task automatic drain();
        while (pending_items.size() != 0 || item_valid || expected_gains.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic begin_phase(input logic [31:0] debounce, input logic [31:0] ramp,
                               input bit idling);
        drain();
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_RAMP, ramp);
        idle_on = idling;
    endtask

    // mostly small intervals, with the extremes and full-width values mixed in
    function automatic logic [31:0] pick_ticks(input int unsigned span);
        case ($urandom_range(9, 0))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return '1;
            3:       return $urandom;
            default: return $urandom_range(span, 0);
        endcase
    endfunction

    // step bound: steps of this size cross debounce and ramp in roughly a dozen words
    function automatic logic [31:0] step_limit(input logic [31:0] debounce,
                                               input logic [31:0] ramp);
        logic [33:0] span;
        span = (34'(debounce) + 34'(ramp)) / 12 + 34'd2;
        return span[31:0];
    endfunction

    // forward-running timestamps with held contacts, some backward steps and
    // some fully random words as noise
    task automatic queue_walk(input int count, input logic [31:0] step_max);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99, 0);
            if (roll < 5) begin
                walk_stamp = $urandom;
                walk_left  = 1'($urandom);
                walk_right = 1'($urandom);
            end else if (roll < 10) begin
                walk_stamp = walk_stamp - $urandom_range(step_max, 1);
            end else begin
                walk_stamp = walk_stamp + $urandom_range(step_max, 0);
            end
            if ($urandom_range(99, 0) < 8)
                walk_left = ~walk_left;
            if ($urandom_range(99, 0) < 8)
                walk_right = ~walk_right;
            push_item(walk_stamp, walk_left, walk_right);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] debounce;
        logic [31:0] ramp;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // debounce 10, ramp 100: boundary, ramp, saturation, time backwards
        begin_phase(32'd10, 32'd100, 1'b0);
        push_item(32'd0, 1'b1, 1'b1);
        push_item(32'd9, 1'b1, 1'b1);          // just inside debounce
        push_item(32'd10, 1'b1, 1'b1);         // ramp starts at zero
        push_item(32'd11, 1'b1, 1'b0);         // right lifted
        push_item(32'd60, 1'b1, 1'b1);         // mid ramp, right re-latches
        push_item(32'd110, 1'b1, 1'b1);        // left saturates
        push_item(32'd5, 1'b1, 1'b1);          // time backwards, right re-latches
        push_item(32'd16, 1'b0, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b1, 1'b1);  // top of the time range
        push_item(32'd0, 1'b1, 1'b1);

        // zero debounce, zero ramp: plain step
        begin_phase(32'd0, 32'd0, 1'b0);
        push_item(32'd0, 1'b1, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_item(32'd7, 1'b0, 1'b1);

        // both registers at full scale: boundary reached only at the far end
        begin_phase('1, '1, 1'b0);
        push_item(32'd0, 1'b1, 1'b1);
        push_item(32'hFFFF_FFFE, 1'b1, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b1, 1'b1);

        // full debounce, step ramp
        begin_phase('1, 32'd0, 1'b0);
        push_item(32'd0, 1'b1, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b1, 1'b1);

        // shortest ramp
        begin_phase(32'd0, 32'd1, 1'b0);
        push_item(32'd3, 1'b1, 1'b1);
        push_item(32'd4, 1'b1, 1'b1);

        // longest ramp with no debounce
        begin_phase(32'd0, '1, 1'b0);
        push_item(32'd0, 1'b1, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b1, 1'b1);
        push_item(32'h8000_0000, 1'b1, 1'b1);

        // random walks, new register setting per phase; last phase runs calm
        for (int phase = 0; phase < 11; phase++) begin
            debounce = pick_ticks(60);
            ramp     = pick_ticks(300);
            begin_phase(debounce, ramp, (phase != 10) && ($urandom_range(3, 0) != 0));
            walk_stamp = $urandom;
            walk_left  = 1'($urandom);
            walk_right = 1'($urandom);
            queue_walk(50, step_limit(debounce, ramp));
        end

        drain();
        if (errors == 0)
            $display("** contact_debounce_ramp_gate: PASSED **");
        else
            $display("** contact_debounce_ramp_gate: FAILED **");
        $finish;
    end

endmodule
